// ===== design/mcb_pkg.sv =====
// Package for the box filter mip chain unit.
// Holds shared types, sizes and codes; depends on nothing.
package mcb_pkg;

	localparam int NLEV = 9;
	localparam int LVW  = 4;
	localparam int CHW  = 8;
	localparam int SUMW = 10;
	localparam int NCH  = 4;

	localparam logic [1:0] REG_WIDTH   = 2'd0;
	localparam logic [1:0] REG_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_CHANNEL = 2'd2;
	localparam logic [1:0] REG_MIP     = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_CALC
	} seq_state_t;

	typedef struct packed {
		logic       use_hold;
		logic       use_row;
		logic [1:0] shift;
	} lane_ctl_t;

endpackage

// ===== design/box_filter_mip_chain_unit.sv =====
// Top level of the box filter mip chain unit: level sequencer, lanes, result register.
// Depends on mcb_pkg, mcb_lane and mcb_rowmem.
//
//  channel | signals                                  | moves
//  input   | in_valid, in_stall, sample_c0..c3        | one base pixel word
//  output  | out_valid, out_stall, mip_level, pos_*,  | one result word
//          | out_c0..c3, run_last                     |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| one register write
//
// An item yields 1 to 9 results: it is accepted, then level zero is emitted, and each further
// level that the item completes takes a row pair store read step and an emit step.
// Reset clears control state and the config registers to 1, 1, 4, 1.
// Output stall holds the sequencer at its emit step; input stays stalled until
// the last result of the word is loaded into the result register.
module box_filter_mip_chain_unit #(
	parameter int MAX_DIM = 256,
	parameter int LANES   = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] sample_c0,
	input  logic [7:0] sample_c1,
	input  logic [7:0] sample_c2,
	input  logic [7:0] sample_c3,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] mip_level,
	output logic [7:0] pos_x,
	output logic [7:0] pos_y,
	output logic [7:0] out_c0,
	output logic [7:0] out_c1,
	output logic [7:0] out_c2,
	output logic [7:0] out_c3,
	output logic       run_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);
	localparam int DIMW = $clog2(MAX_DIM + 1);
	localparam int PW   = $clog2(MAX_DIM);
	localparam int TXN  = (MAX_DIM - 1) / 2 + 1;
	localparam int TXW  = (TXN > 1) ? $clog2(TXN) : 1;
	localparam int AW   = mcb_pkg::LVW + TXW;
	localparam int MW   = LANES * mcb_pkg::SUMW;

	logic [8:0] cfg_w_q, cfg_h_q;
	logic [2:0] cfg_ch_q;
	logic       cfg_mip_q;

	mcb_pkg::seq_state_t state_q, state_d;

	logic [DIMW-1:0] w_q, h_q, cw_q, ch_q;
	logic [mcb_pkg::LVW-1:0] total_q, k_q;
	logic [LANES-1:0] en_q;
	logic [PW-1:0] bx_q, by_q, px_q, py_q;
	logic [mcb_pkg::CHW-1:0] val_q [LANES];
	logic [mcb_pkg::SUMW-1:0] hsum_q [LANES];
	logic [mcb_pkg::CHW-1:0] hold_q [mcb_pkg::NLEV][LANES];
	logic row_q;
	logic [1:0] shift_q;

	logic out_valid_q, out_last_q;
	logic [3:0] out_lvl_q;
	logic [7:0] out_x_q, out_y_q;
	logic [mcb_pkg::CHW-1:0] out_val_q [LANES];

	logic [7:0] sample [mcb_pkg::NCH];
	logic [DIMW-1:0] w_c, h_c, m_c, w_eff, h_eff, nw, nh;
	logic [mcb_pkg::LVW-1:0] tot_c, kn;
	logic [LANES-1:0] en_c, en_eff;
	logic first, accept, out_free, emit, go_up, even_x, even_y, nxt;
	logic [PW-1:0] nbx, nby;
	logic [TXW-1:0] tx, ty;
	mcb_pkg::lane_ctl_t ctl;
	logic [mcb_pkg::SUMW-1:0] hsum [LANES];
	logic [mcb_pkg::CHW-1:0] mean [LANES];
	logic [MW-1:0] wdata, rdata;
	logic mem_we, mem_re;
	logic [AW-1:0] addr;

	function automatic logic [DIMW-1:0] clamp_dim(input logic [8:0] v);
		logic [DIMW-1:0] r;
		if (v == 9'd0)
			r = DIMW'(1);
		else if (32'(v) > MAX_DIM)
			r = DIMW'(MAX_DIM);
		else
			r = DIMW'(v);
		return r;
	endfunction

	function automatic logic [DIMW-1:0] half_dim(input logic [DIMW-1:0] v);
		logic [DIMW-1:0] r;
		r = v >> 1;
		if (r == '0)
			r = DIMW'(1);
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign sample[0] = sample_c0;
	assign sample[1] = sample_c1;
	assign sample[2] = sample_c2;
	assign sample[3] = sample_c3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q   <= 9'd1;
			cfg_h_q   <= 9'd1;
			cfg_ch_q  <= 3'd4;
			cfg_mip_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				mcb_pkg::REG_WIDTH:   cfg_w_q   <= cfg_data;
				mcb_pkg::REG_HEIGHT:  cfg_h_q   <= cfg_data;
				mcb_pkg::REG_CHANNEL: cfg_ch_q  <= cfg_data[2:0];
				mcb_pkg::REG_MIP:     cfg_mip_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_c = clamp_dim(cfg_w_q);
		h_c = clamp_dim(cfg_h_q);
		m_c = (w_c > h_c) ? w_c : h_c;
		tot_c = mcb_pkg::LVW'(1);
		for (int i = 1; i < DIMW; i++)
			if (m_c[i])
				tot_c = mcb_pkg::LVW'(i + 1);
		if (!cfg_mip_q)
			tot_c = mcb_pkg::LVW'(1);
		for (int i = 0; i < LANES; i++)
			en_c[i] = (i == 0) || (32'(cfg_ch_q) > i);
		first = (bx_q == '0) && (by_q == '0);
		w_eff = first ? w_c : w_q;
		h_eff = first ? h_c : h_q;
		en_eff = first ? en_c : en_q;
		nbx = bx_q + PW'(1);
		nby = by_q;
		if (32'(bx_q) + 32'd1 >= 32'(w_eff)) begin
			nbx = '0;
			nby = by_q + PW'(1);
			if (32'(by_q) + 32'd1 >= 32'(h_eff))
				nby = '0;
		end
	end

	always_comb begin
		nw = half_dim(cw_q);
		nh = half_dim(ch_q);
		kn = k_q + mcb_pkg::LVW'(1);
		tx = (cw_q > DIMW'(1)) ? TXW'(px_q >> 1) : '0;
		ty = (ch_q > DIMW'(1)) ? TXW'(py_q >> 1) : '0;
		go_up = (kn < total_q) && (32'(tx) < 32'(nw)) && (32'(ty) < 32'(nh));
		even_x = (cw_q > DIMW'(1)) && !px_q[0];
		even_y = (ch_q > DIMW'(1)) && !py_q[0];
		nxt = go_up && !even_x && !even_y;
		out_free = !out_valid_q || !out_stall;
		ctl.use_hold = cw_q > DIMW'(1);
		ctl.use_row = row_q;
		ctl.shift = shift_q;
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		accept = 1'b0;
		emit = 1'b0;
		case (state_q)
			mcb_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				accept = in_valid;
				if (in_valid)
					state_d = mcb_pkg::ST_EMIT;
			end
			mcb_pkg::ST_EMIT: begin
				emit = out_free;
				if (out_free)
					state_d = nxt ? mcb_pkg::ST_CALC : mcb_pkg::ST_IDLE;
			end
			mcb_pkg::ST_CALC: state_d = mcb_pkg::ST_EMIT;
			default: state_d = mcb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcb_pkg::ST_IDLE;
			bx_q <= '0;
			by_q <= '0;
			out_valid_q <= 1'b0;
			total_q <= mcb_pkg::LVW'(1);
		end else begin
			state_q <= state_d;
			if (accept) begin
				bx_q <= nbx;
				by_q <= nby;
				if (first)
					total_q <= tot_c;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	generate
		for (genvar i = 0; i < LANES; i++) begin : g_lane
			mcb_lane u_lane (
				.pix     (val_q[i]),
				.hold    (hold_q[kn][i]),
				.row     (rdata[i*mcb_pkg::SUMW +: mcb_pkg::SUMW]),
				.hsum_in (hsum_q[i]),
				.ctl     (ctl),
				.hsum    (hsum[i]),
				.mean    (mean[i])
			);
			assign wdata[i*mcb_pkg::SUMW +: mcb_pkg::SUMW] = hsum[i];
		end
	endgenerate

	assign addr = {kn, tx};
	assign mem_we = emit && go_up && !even_x && even_y;
	assign mem_re = emit && nxt;

	mcb_rowmem #(.AW(AW), .DW(MW)) u_rowmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr),
		.wdata (wdata),
		.re    (mem_re),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			if (first) begin
				w_q <= w_c;
				h_q <= h_c;
				en_q <= en_c;
			end
			k_q <= '0;
			px_q <= bx_q;
			py_q <= by_q;
			cw_q <= w_eff;
			ch_q <= h_eff;
			for (int i = 0; i < LANES; i++)
				val_q[i] <= en_eff[i] ? sample[i] : '0;
		end
		if (emit) begin
			out_lvl_q <= k_q;
			out_x_q <= 8'(px_q);
			out_y_q <= 8'(py_q);
			out_last_q <= !nxt;
			for (int i = 0; i < LANES; i++)
				out_val_q[i] <= val_q[i];
			if (go_up && even_x)
				for (int i = 0; i < LANES; i++)
					hold_q[kn][i] <= val_q[i];
			if (nxt) begin
				k_q <= kn;
				px_q <= PW'(tx);
				py_q <= PW'(ty);
				cw_q <= nw;
				ch_q <= nh;
				row_q <= ch_q > DIMW'(1);
				shift_q <= 2'(ctl.use_hold) + 2'(ch_q > DIMW'(1));
				for (int i = 0; i < LANES; i++)
					hsum_q[i] <= hsum[i];
			end
		end
		if (state_q == mcb_pkg::ST_CALC)
			for (int i = 0; i < LANES; i++)
				val_q[i] <= mean[i];
	end

	assign out_valid = out_valid_q;
	assign mip_level = out_lvl_q;
	assign pos_x = out_x_q;
	assign pos_y = out_y_q;
	assign run_last = out_last_q;
	assign out_c0 = out_val_q[0];
	assign out_c1 = (LANES > 1) ? out_val_q[(LANES > 1) ? 1 : 0] : 8'd0;
	assign out_c2 = (LANES > 2) ? out_val_q[(LANES > 2) ? 2 : 0] : 8'd0;
	assign out_c3 = (LANES > 3) ? out_val_q[(LANES > 3) ? 3 : 0] : 8'd0;
endmodule

// ===== design/mcb_lane.sv =====
// One channel lane of the mip chain unit: column pair sum and mean of up to 2x2 pixels.
// Depends on mcb_pkg.
module mcb_lane (
	input  logic [mcb_pkg::CHW-1:0]  pix,
	input  logic [mcb_pkg::CHW-1:0]  hold,
	input  logic [mcb_pkg::SUMW-1:0] row,
	input  logic [mcb_pkg::SUMW-1:0] hsum_in,
	input  mcb_pkg::lane_ctl_t       ctl,
	output logic [mcb_pkg::SUMW-1:0] hsum,
	output logic [mcb_pkg::CHW-1:0]  mean
);
	logic [mcb_pkg::SUMW-1:0] total;

	always_comb begin
		hsum = ctl.use_hold ? mcb_pkg::SUMW'(hold) + mcb_pkg::SUMW'(pix)
			: mcb_pkg::SUMW'(pix);
		total = (ctl.use_row ? row : '0) + hsum_in;
		mean = mcb_pkg::CHW'(total >> ctl.shift);
	end
endmodule

// ===== design/mcb_rowmem.sv =====
// Row pair sum store of the mip chain unit: one write and one registered read port.
// Depends on nothing.
module mcb_rowmem #(
	parameter int AW = 11,
	parameter int DW = 40
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ===== tb/box_filter_mip_chain_unit_test.sv =====
// Testbench for box_filter_mip_chain_unit: streams base images, predicts every mip result.
// Depends on mcb_pkg and the unit RTL; scoreboard class holds the mip chain predictor.

typedef struct {
	logic [3:0] lvl;
	logic [7:0] x;
	logic [7:0] y;
	logic [7:0] c [4];
	logic       last;
} mip_word_t;

class mip_chain_board;
	int unsigned img_w, img_h, chans, mips;
	int unsigned cur_w, cur_h, cur_lanes, cur_levels;
	int unsigned lvl_w [13];
	int unsigned lvl_h [13];
	int unsigned row_sums [13][129][4];
	int unsigned col_hold [13][4];
	int unsigned pos_x, pos_y;
	mip_word_t pending [$];
	int errors;

	function new();
		img_w = 1; img_h = 1; chans = 4; mips = 1;
		pos_x = 0; pos_y = 0; errors = 0;
		foreach (col_hold[k, c]) col_hold[k][c] = 0;
		latch_sizes();
		cur_levels = 1;
	endfunction

	function int unsigned fit_dim(int unsigned v);
		if (v == 0) return 1;
		if (v > 256) return 256;
		return v;
	endfunction

	function void latch_sizes();
		int unsigned m, top;
		cur_w = fit_dim(img_w);
		cur_h = fit_dim(img_h);
		m = cur_w > cur_h ? cur_w : cur_h;
		top = 0;
		while (m > 1) begin
			m >>= 1;
			top++;
		end
		cur_levels = mips ? top + 1 : 1;
		lvl_w[0] = cur_w;
		lvl_h[0] = cur_h;
		for (int k = 1; k < 13; k++) begin
			lvl_w[k] = (lvl_w[k-1] >> 1) ? lvl_w[k-1] >> 1 : 1;
			lvl_h[k] = (lvl_h[k-1] >> 1) ? lvl_h[k-1] >> 1 : 1;
		end
		cur_lanes = chans == 0 ? 1 : (chans > 4 ? 4 : chans);
	endfunction

	function void set_reg(logic [1:0] idx, logic [8:0] v);
		case (idx)
			mcb_pkg::REG_WIDTH: img_w = 32'(v);
			mcb_pkg::REG_HEIGHT: img_h = 32'(v);
			mcb_pkg::REG_CHANNEL: chans = 32'(v[2:0]);
			mcb_pkg::REG_MIP: mips = 32'(v[0]);
			default: ;
		endcase
	endfunction

	function void add_word(int unsigned lvl, int unsigned x, int unsigned y,
			int unsigned v [4]);
		mip_word_t w;
		w.lvl = 4'(lvl); w.x = 8'(x); w.y = 8'(y); w.last = 0;
		for (int c = 0; c < 4; c++) w.c[c] = c < cur_lanes ? v[c][7:0] : 8'd0;
		pending = {pending, w};
	endfunction

	function void note_pixel(logic [7:0] s [4]);
		int unsigned v [4];
		int unsigned hs [4];
		int unsigned px, py, pw, ph, tx, ty, sh;
		if (pos_x == 0 && pos_y == 0) latch_sizes();
		px = pos_x; py = pos_y;
		for (int c = 0; c < 4; c++) v[c] = c < cur_lanes ? 32'(s[c]) : 0;
		add_word(0, px, py, v);
		pos_x = px + 1;
		if (pos_x >= lvl_w[0]) begin
			pos_x = 0;
			pos_y = py + 1;
			if (pos_y >= lvl_h[0]) pos_y = 0;
		end
		for (int k = 1; k < cur_levels; k++) begin
			pw = lvl_w[k-1]; ph = lvl_h[k-1];
			tx = pw > 1 ? px >> 1 : 0;
			ty = ph > 1 ? py >> 1 : 0;
			sh = 0;
			if (tx >= lvl_w[k] || ty >= lvl_h[k]) break;
			if (pw > 1) begin
				if (!px[0]) begin
					col_hold[k] = v;
					break;
				end
				for (int c = 0; c < 4; c++) hs[c] = (col_hold[k][c] + v[c]) & 16'hffff;
				sh++;
			end else begin
				hs = v;
			end
			if (ph > 1) begin
				if (!py[0]) begin
					row_sums[k][tx] = hs;
					break;
				end
				for (int c = 0; c < 4; c++) hs[c] = (row_sums[k][tx][c] + hs[c]) & 16'hffff;
				sh++;
			end
			for (int c = 0; c < 4; c++) v[c] = hs[c] >> sh;
			add_word(k, tx, ty, v);
			px = tx; py = ty;
		end
		pending[pending.size()-1].last = 1;
	endfunction

	function void check_word(mip_word_t a);
		mip_word_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result lvl %0d x %0d y %0d", $time, a.lvl, a.x, a.y);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (e.lvl !== a.lvl || e.x !== a.x || e.y !== a.y || e.last !== a.last ||
				e.c[0] !== a.c[0] || e.c[1] !== a.c[1] || e.c[2] !== a.c[2] ||
				e.c[3] !== a.c[3]) begin
			$display("%0t: expected lvl %0d x %0d y %0d c %h %h %h %h last %0d",
				$time, e.lvl, e.x, e.y, e.c[0], e.c[1], e.c[2], e.c[3], e.last);
			$display("%0t: actual   lvl %0d x %0d y %0d c %h %h %h %h last %0d",
				$time, a.lvl, a.x, a.y, a.c[0], a.c[1], a.c[2], a.c[3], a.last);
			errors++;
		end
	endfunction
endclass

module box_filter_mip_chain_unit_test;
	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	logic [7:0] sample_c0 = 0, sample_c1 = 0, sample_c2 = 0, sample_c3 = 0;
	logic       out_valid;
	logic       out_stall = 1;
	logic [3:0] mip_level;
	logic [7:0] pos_x, pos_y, out_c0, out_c1, out_c2, out_c3;
	logic       run_last;
	logic       cfg_valid = 0;
	logic       cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [8:0] cfg_data = 0;

	mip_chain_board board = new();
	int  idle_pct = 25;

	box_filter_mip_chain_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		mip_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			w.lvl = mip_level; w.x = pos_x; w.y = pos_y; w.last = run_last;
			w.c[0] = out_c0; w.c[1] = out_c1; w.c[2] = out_c2; w.c[3] = out_c3;
			board.check_word(w);
		end
	end

	always @(negedge clk)
		if (arst_n) out_stall <= $urandom_range(99) < idle_pct;

	task automatic write_reg(logic [1:0] idx, logic [8:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
		logic [7:0] s [4];
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		sample_c0 <= a; sample_c1 <= b; sample_c2 <= c; sample_c3 <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		s = '{a, b, c, d};
		board.note_pixel(s);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic send_image(int unsigned w, int unsigned h, int unsigned pat);
		for (int unsigned i = 0; i < w * h; i++) begin
			case (pat)
				0: send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
				1: send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
				default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
			endcase
		end
	endtask

	task automatic config_image(int unsigned w, int unsigned h, int unsigned ch, int unsigned m);
		write_reg(mcb_pkg::REG_WIDTH, 9'(w));
		write_reg(mcb_pkg::REG_HEIGHT, 9'(h));
		write_reg(mcb_pkg::REG_CHANNEL, 9'(ch));
		write_reg(mcb_pkg::REG_MIP, 9'(m));
	endtask

	initial begin
		int unsigned w, h;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
		drain();
		config_image(4, 2, 4, 1);
		send_image(4, 2, 0);
		drain();
		config_image(1, 4, 0, 1);
		send_image(1, 4, 2);
		drain();
		config_image(3, 3, 7, 1);
		send_image(3, 3, 1);
		drain();
		config_image(2, 2, 2, 0);
		send_image(2, 2, 2);
		drain();
		for (int n = 0; n < 2; n++) begin
			w = $urandom_range(1, 4);
			h = $urandom_range(1, 4);
			config_image(w, h, $urandom_range(0, 7), $urandom_range(0, 9) != 0);
			send_image(w, h, 2);
			drain();
		end
		idle_pct = 0;
		config_image(8, 8, 4, 1);
		send_image(8, 8, 2);
		drain();
		idle_pct = 25;
		config_image(0, 511, 3, 1);
		send_pixel(8'hff, 8'h00, 8'haa, 8'h55);
		send_pixel(8'h01, 8'h80, 8'h7f, 8'hfe);
		drain();
		config_image(256, 1, 4, 1);
		send_pixel(8'h0f, 8'hf0, 8'h3c, 8'hc3);
		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("box_filter_mip_chain_unit_test passed");
		else
			$display("box_filter_mip_chain_unit_test failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("box_filter_mip_chain_unit_test failed");
		$finish;
	end
endmodule
